>>> rtl/vml_pkg.sv
package vml_pkg;

    localparam int CompW = 16;
    localparam int LimW  = 16;

    typedef struct packed {
        logic signed [CompW-1:0] x_in;
        logic signed [CompW-1:0] y_in;
    } t_vec_in;

    typedef struct packed {
        logic signed [CompW-1:0] x_out;
        logic signed [CompW-1:0] y_out;
        logic                    was_limited;
    } t_vec_out;

endpackage

>>> rtl/vml_sqrt.sv
module vml_sqrt #(
    parameter int W  = 16,
    parameter int TW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [2*W-1:0] i_rad,
    input  logic [TW-1:0]  i_tag,
    output logic           o_valid,
    output logic [W-1:0]   o_root,
    output logic [TW-1:0]  o_tag
);

    logic           r_vld  [W];
    logic [2*W-1:0] r_rad  [W];
    logic [W+1:0]   r_rem  [W];
    logic [W-1:0]   r_root [W];
    logic [TW-1:0]  r_tag  [W];

    // one root bit per stage, most significant first
    for (genvar s = 0; s < W; s++) begin : g_stage
        localparam int K = W - 1 - s;
        logic           vld_in;
        logic [2*W-1:0] rad_in;
        logic [W+1:0]   rem_in;
        logic [W-1:0]   root_in;
        logic [TW-1:0]  tag_in;
        logic [W+1:0]   rem_sh;
        logic [W+1:0]   trial;
        logic           ge;
        logic [W+1:0]   n_rem;
        logic [W-1:0]   n_root;

        if (s == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign tag_in  = i_tag;
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign rad_in  = r_rad[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign tag_in  = r_tag[s-1];
        end

        always_comb begin
            rem_sh = {rem_in[W-1:0], rad_in[2*K+1 -: 2]};
            trial  = {root_in, 2'b01};
            ge     = rem_sh >= trial;
            n_rem  = ge ? rem_sh - trial : rem_sh;
            n_root = {root_in[W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s]  <= rad_in;
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_tag[s]  <= tag_in;
            end
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_root  = r_root[W-1];
    assign o_tag   = r_tag[W-1];

endmodule

>>> rtl/vml_div.sv
module vml_div #(
    parameter int W  = 16,
    parameter int LW = 16,
    parameter int TW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [W+LW-1:0] i_num,
    input  logic [W-1:0]    i_den,
    input  logic [TW-1:0]   i_tag,
    output logic            o_valid,
    output logic [W-1:0]    o_quo,
    output logic [TW-1:0]   o_tag
);

    logic            r_vld [W];
    logic [W+LW-1:0] r_num [W];
    logic [W-1:0]    r_den [W];
    logic [W-1:0]    r_rem [W];
    logic [W-1:0]    r_quo [W];
    logic [TW-1:0]   r_tag [W];

    // quotient fits W bits, so the upper dividend part starts below the divisor
    for (genvar s = 0; s < W; s++) begin : g_stage
        localparam int K = W - 1 - s;
        logic            vld_in;
        logic [W+LW-1:0] num_in;
        logic [W-1:0]    den_in;
        logic [W-1:0]    rem_in;
        logic [W-1:0]    quo_in;
        logic [TW-1:0]   tag_in;
        logic [W:0]      trial;
        logic            ge;
        logic [W-1:0]    n_rem;
        logic [W-1:0]    n_quo;

        if (s == 0) begin : g_first
            assign vld_in = i_valid;
            assign num_in = i_num;
            assign den_in = i_den;
            assign rem_in = W'(i_num[W+LW-1:W]);
            assign quo_in = '0;
            assign tag_in = i_tag;
        end else begin : g_next
            assign vld_in = r_vld[s-1];
            assign num_in = r_num[s-1];
            assign den_in = r_den[s-1];
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign tag_in = r_tag[s-1];
        end

        always_comb begin
            trial = {rem_in, num_in[K]};
            ge    = trial >= {1'b0, den_in};
            n_rem = ge ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
            n_quo = {quo_in[W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s] <= num_in;
                r_den[s] <= den_in;
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_tag[s] <= tag_in;
            end
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quo   = r_quo[W-1];
    assign o_tag   = r_tag[W-1];

endmodule

>>> rtl/vector_magnitude_limiter_unit.sv
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output register is full and i_stall is high.
// Stages: input, squares, sum and compare, one sqrt bit per stage, one quotient
// bit per stage, output. Reset empties the pipeline and loads limit 32767.
module vector_magnitude_limiter_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [vml_pkg::LimW-1:0] i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  vml_pkg::t_vec_in        i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output vml_pkg::t_vec_out       o_data
);

    localparam int W    = vml_pkg::CompW;
    localparam int LW   = vml_pkg::LimW;
    localparam int CmpW = (2 * W > 2 * LW) ? 2 * W : 2 * LW;
    localparam int TagS = 2 + 2 * W + 2 * (W + LW) + 1;
    localparam int TagX = 2 + W;
    localparam int TagY = 1 + W;

    logic          en;
    logic [LW-1:0] r_lim;

    // stage 0
    logic         r0_vld;
    logic         r0_xn, r0_yn;
    logic [W-1:0] r0_ax, r0_ay;
    // stage 1
    logic          r1_vld;
    logic          r1_xn, r1_yn;
    logic [W-1:0]  r1_ax, r1_ay;
    logic [2*W-1:0] r1_sqx, r1_sqy;
    logic [2*LW-1:0] r1_lsq;
    // stage 2
    logic           r2_vld;
    logic           r2_xn, r2_yn;
    logic [W-1:0]   r2_ax, r2_ay;
    logic [2*W-1:0] r2_sum;
    logic           r2_over;
    logic [W+LW-1:0] r2_px, r2_py;

    logic           s_vld;
    logic [W-1:0]   s_root;
    logic [TagS-1:0] s_tag;
    logic           s_xn, s_yn, s_over;
    logic [W-1:0]   s_ax, s_ay;
    logic [W+LW-1:0] s_px, s_py;

    logic           dx_vld, dy_vld;
    logic [W-1:0]   dx_quo, dy_quo;
    logic [TagX-1:0] dx_tag;
    logic [TagY-1:0] dy_tag;

    logic           r_out_vld;
    vml_pkg::t_vec_out r_out;
    vml_pkg::t_vec_out n_out;
    logic [W-1:0]   rx, ry;

    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= LW'(32767);
        end else if (i_cfg_we) begin
            r_lim <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld    <= 1'b0;
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r0_vld    <= i_valid;
            r1_vld    <= r0_vld;
            r2_vld    <= r1_vld;
            r_out_vld <= dx_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // exact magnitudes, most negative value included
            r0_xn <= i_data.x_in[W-1];
            r0_yn <= i_data.y_in[W-1];
            r0_ax <= i_data.x_in[W-1] ? W'(~i_data.x_in + 1'b1) : W'(i_data.x_in);
            r0_ay <= i_data.y_in[W-1] ? W'(~i_data.y_in + 1'b1) : W'(i_data.y_in);

            r1_xn  <= r0_xn;
            r1_yn  <= r0_yn;
            r1_ax  <= r0_ax;
            r1_ay  <= r0_ay;
            r1_sqx <= r0_ax * r0_ax;
            r1_sqy <= r0_ay * r0_ay;
            r1_lsq <= r_lim * r_lim;

            r2_xn   <= r1_xn;
            r2_yn   <= r1_yn;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_sum  <= r1_sqx + r1_sqy;
            r2_over <= CmpW'(r1_sqx + r1_sqy) > CmpW'(r1_lsq);
            r2_px   <= r1_ax * r_lim;
            r2_py   <= r1_ay * r_lim;

            r_out <= n_out;
        end
    end

    vml_sqrt #(
        .W (W),
        .TW(TagS)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r2_vld),
        .i_rad  (r2_sum),
        .i_tag  ({r2_xn, r2_yn, r2_ax, r2_ay, r2_px, r2_py, r2_over}),
        .o_valid(s_vld),
        .o_root (s_root),
        .o_tag  (s_tag)
    );

    assign {s_xn, s_yn, s_ax, s_ay, s_px, s_py, s_over} = s_tag;

    vml_div #(
        .W (W),
        .LW(LW),
        .TW(TagX)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(s_vld),
        .i_num  (s_px),
        .i_den  (s_root),
        .i_tag  ({s_xn, s_ax, s_over}),
        .o_valid(dx_vld),
        .o_quo  (dx_quo),
        .o_tag  (dx_tag)
    );

    vml_div #(
        .W (W),
        .LW(LW),
        .TW(TagY)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(s_vld),
        .i_num  (s_py),
        .i_den  (s_root),
        .i_tag  ({s_yn, s_ay}),
        .o_valid(dy_vld),
        .o_quo  (dy_quo),
        .o_tag  (dy_tag)
    );

    always_comb begin
        rx = dx_tag[0] ? dx_quo : dx_tag[W:1];
        ry = dx_tag[0] ? dy_quo : dy_tag[W-1:0];
        n_out.x_out       = dx_tag[W+1] ? W'(~rx + 1'b1) : rx;
        n_out.y_out       = dy_tag[W] ? W'(~ry + 1'b1) : ry;
        n_out.was_limited = dx_tag[0] && dy_vld;
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PipeLatency = 2 * vml_pkg::CompW + 4;
    localparam int CW          = vml_pkg::CompW;
    localparam int LimW        = vml_pkg::LimW;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [LimW-1:0]      i_cfg_wdata;
    logic                 i_valid;
    logic                 o_stall;
    vml_pkg::t_vec_in     i_data;
    logic                 o_valid;
    logic                 i_stall;
    vml_pkg::t_vec_out    o_data;

    vector_magnitude_limiter_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    logic [LimW-1:0]   limit_reg;
    vml_pkg::t_vec_out clamped_q[$];
    int                mismatch_cnt;
    bit                hold_off;
    int                burst_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic vml_pkg::t_vec_out clamp_vector(vml_pkg::t_vec_in v,
                                                       logic [LimW-1:0] lim);
        vml_pkg::t_vec_out r;
        logic [63:0]       ax, ay, sum, norm, lim64;
        logic [CW-1:0]     mx, my;
        logic [CW-1:0]     rx, ry;
        mx = v.x_in;
        my = v.y_in;
        if (v.x_in[CW-1]) mx = ~mx + 1'b1;
        if (v.y_in[CW-1]) my = ~my + 1'b1;
        ax    = 64'(mx);
        ay    = 64'(my);
        lim64 = 64'(lim);
        sum   = ax * ax + ay * ay;
        r.was_limited = 1'b0;
        if (sum > lim64 * lim64) begin
            norm = isqrt(sum);
            ax   = (ax * lim64) / norm;
            ay   = (ay * lim64) / norm;
            r.was_limited = 1'b1;
        end
        rx = ax[CW-1:0];
        ry = ay[CW-1:0];
        r.x_out = v.x_in[CW-1] ? -rx : rx;
        r.y_out = v.y_in[CW-1] ? -ry : ry;
        return r;
    endfunction

    // receiver: stall pattern plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off) begin
            i_stall <= 1'b1;
        end else begin
            case ($urandom_range(0, 3))
                0:       i_stall <= 1'b1;
                default: i_stall <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // check each transaction against the oldest expectation
    always @(posedge i_clk) begin
        vml_pkg::t_vec_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (clamped_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result x=%0d y=%0d lim=%0b",
                             o_data.x_out, o_data.y_out, o_data.was_limited);
            end else begin
                want = clamped_q.pop_front();
                if (o_data.x_out !== want.x_out || o_data.y_out !== want.y_out ||
                    o_data.was_limited !== want.was_limited) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp x=%0d y=%0d lim=%0b, got x=%0d y=%0d lim=%0b",
                                 want.x_out, want.y_out, want.was_limited,
                                 o_data.x_out, o_data.y_out, o_data.was_limited);
                end
            end
        end
    end

    task automatic send_vector(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        vml_pkg::t_vec_in v;
        v.x_in = x;
        v.y_in = y;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        clamped_q.push_back(clamp_vector(v, limit_reg));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (clamped_q.size() != 0) @(posedge i_clk);
        repeat (PipeLatency + 4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LimW-1:0] lim);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_reg = lim;
    endtask

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(0, 4))
            0:       return CW'(int'($urandom_range(0, 15)) - 8);
            1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            2:       return CW'(int'($urandom_range(0, 511)) - 256);
            default: return CW'($urandom());
        endcase
    endfunction

    task automatic test_corners();
        send_vector('0, '0);
        send_vector(16'h8000, 16'h8000);
        send_vector(16'h7fff, 16'h7fff);
        send_vector(16'h8000, '0);
        send_vector('0, 16'h7fff);
        send_vector(CW'(-1), CW'(1));
        send_vector(16'h7fff, 16'h8000);
        send_vector(CW'(3000), CW'(-4000));
    endtask

    task automatic test_zero_limit();
        write_limit('0);
        send_vector('0, '0);
        send_vector(CW'(1), '0);
        send_vector(16'h8000, CW'(-1));
        send_vector(CW'(-5), CW'(7));
    endtask

    task automatic test_max_limit();
        write_limit(16'hffff);
        send_vector(16'h8000, 16'h8000);
        send_vector(16'h7fff, 16'h8000);
        send_vector(CW'(-300), CW'(400));
    endtask

    task automatic test_small_limit();
        write_limit(LimW'(5));
        send_vector(CW'(3), CW'(4));
        send_vector(CW'(3), CW'(5));
        send_vector(CW'(-6), CW'(8));
        send_vector(16'h8000, 16'h7fff);
    endtask

    task automatic test_random();
        logic [LimW-1:0] lims[5];
        lims = '{16'd1, 16'd100, 16'd32767, 16'd46341, LimW'($urandom())};
        foreach (lims[k]) begin
            write_limit(lims[k]);
            repeat (115) send_vector(rand_comp(), rand_comp());
        end
    endtask

    task automatic test_backpressure();
        write_limit(LimW'(1000));
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (60) send_vector(rand_comp(), rand_comp());
        join
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        hold_off     = 1'b0;
        burst_left   = 0;
        mismatch_cnt = 0;
        limit_reg    = 16'd32767;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_zero_limit();
        test_max_limit();
        test_small_limit();
        test_random();
        test_backpressure();
        wait_drained();

        if (mismatch_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/vml_pkg.sv
rtl/vml_sqrt.sv
rtl/vml_div.sv
rtl/vector_magnitude_limiter_unit.sv
tb/testbench.sv
